// ===== design/lli_pkg.sv =====
// ---------------------------------------------------------------------------
// lli_pkg
// Shared constants for the line-line intersection pipeline.
// ---------------------------------------------------------------------------
`default_nettype none
package lli_pkg;
  localparam int unsigned COORD_BITS_DEF = 16;
  localparam int unsigned FRAC_BITS_DEF  = 16;
  localparam int unsigned OUT_W          = 32;
  // Quotient bits kept; anything at or above 2^QUOT_BITS saturates.
  localparam int unsigned QUOT_BITS      = OUT_W + 1;
endpackage
`default_nettype wire

// ===== design/lli_if.sv =====
// ---------------------------------------------------------------------------
// lli_in_if / lli_out_if
// Valid/ready channels carrying a line pair and a crossing point.
// ---------------------------------------------------------------------------
`default_nettype none
interface lli_in_if #(parameter int unsigned COORD_BITS = 16);
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] first_start_x;
  logic signed [COORD_BITS-1:0] first_start_y;
  logic signed [COORD_BITS-1:0] first_end_x;
  logic signed [COORD_BITS-1:0] first_end_y;
  logic signed [COORD_BITS-1:0] second_start_x;
  logic signed [COORD_BITS-1:0] second_start_y;
  logic signed [COORD_BITS-1:0] second_end_x;
  logic signed [COORD_BITS-1:0] second_end_y;
  modport source (output valid, first_start_x, first_start_y, first_end_x, first_end_y,
                  second_start_x, second_start_y, second_end_x, second_end_y,
                  input ready);
  modport sink (input valid, first_start_x, first_start_y, first_end_x, first_end_y,
                second_start_x, second_start_y, second_end_x, second_end_y,
                output ready);
endinterface

interface lli_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] cross_x;
  logic signed [31:0] cross_y;
  logic               found;
  logic               overflowed;
  modport source (output valid, cross_x, cross_y, found, overflowed, input ready);
  modport sink (input valid, cross_x, cross_y, found, overflowed, output ready);
endinterface
`default_nettype wire

// ===== design/line_line_intersection.sv =====
// Each accepted word passes the coefficient, determinant, magnitude, setup, divider and output stages in order.
// Throughput: one line pair per cycle; each stage holds when the one after it is full.
// The quotient comes from a restoring divider unrolled one bit per register stage.
// Reset (rst_ni low, asynchronous) empties every stage; payload registers are not reset.
// ---------------------------------------------------------------------------
// line_line_intersection
// Crossing point of two lines by Cramer's rule, rounded Q16.16 with saturation.
// ---------------------------------------------------------------------------
`default_nettype none
module line_line_intersection #(
  parameter int unsigned COORD_BITS = lli_pkg::COORD_BITS_DEF,
  parameter int unsigned FRAC_BITS  = lli_pkg::FRAC_BITS_DEF
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  lli_in_if.sink    in_i,
  lli_out_if.source out_o
);
  import lli_pkg::*;

  localparam int unsigned CW  = COORD_BITS;
  localparam int unsigned CCW = 2 * CW + 1;          // c, f
  localparam int unsigned DW  = 2 * CW + 3;          // det
  localparam int unsigned NNW = 3 * CW + 3;          // numerators
  localparam int unsigned MW  = NNW + FRAC_BITS;
  localparam int unsigned WW  = (MW > DW + QUOT_BITS + 1) ? MW : DW + QUOT_BITS + 1;
  localparam int unsigned NS  = QUOT_BITS + 5;       // total stages

  typedef struct packed {
    logic [WW-1:0]        r;
    logic [QUOT_BITS-1:0] q;
    logic                 neg;
    logic                 sat;
  } lane_t;

  // stage valid and advance chain
  logic [NS-1:0] v_q;
  logic [NS-1:0] en;

  always_comb begin
    en[NS-1] = !v_q[NS-1] || out_o.ready;
    for (int k = NS - 2; k >= 0; k--) begin
      en[k] = !v_q[k] || en[k+1];
    end
  end

  assign in_i.ready = en[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (en[0]) v_q[0] <= in_i.valid;
      for (int k = 1; k < NS; k++) begin
        if (en[k]) v_q[k] <= v_q[k-1];
      end
    end
  end

  // stage 0: line coefficients
  logic signed [CW:0]    a_q, b_q, dd_q, e_q;
  logic signed [CCW-1:0] c_q, f_q;
  logic signed [CCW-1:0] c1, c2, f1, f2;

  always_comb begin
    c1 = CCW'(in_i.first_start_x) * CCW'(in_i.first_end_y);
    c2 = CCW'(in_i.first_end_x) * CCW'(in_i.first_start_y);
    f1 = CCW'(in_i.second_start_x) * CCW'(in_i.second_end_y);
    f2 = CCW'(in_i.second_end_x) * CCW'(in_i.second_start_y);
  end

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      a_q  <= (CW+1)'(in_i.first_start_y) - (CW+1)'(in_i.first_end_y);
      b_q  <= (CW+1)'(in_i.first_end_x) - (CW+1)'(in_i.first_start_x);
      dd_q <= (CW+1)'(in_i.second_start_y) - (CW+1)'(in_i.second_end_y);
      e_q  <= (CW+1)'(in_i.second_end_x) - (CW+1)'(in_i.second_start_x);
      c_q  <= c1 - c2;
      f_q  <= f1 - f2;
    end
  end

  // stage 1: determinant and numerators
  logic signed [DW-1:0]  det_q;
  logic signed [NNW-1:0] nx_q, ny_q;
  logic signed [DW-1:0]  ae, bd;
  logic signed [NNW-1:0] bf, ce, cd, af;

  always_comb begin
    ae = DW'(a_q) * DW'(e_q);
    bd = DW'(b_q) * DW'(dd_q);
    bf = NNW'(b_q) * NNW'(f_q);
    ce = NNW'(c_q) * NNW'(e_q);
    cd = NNW'(c_q) * NNW'(dd_q);
    af = NNW'(a_q) * NNW'(f_q);
  end

  always_ff @(posedge clk_i) begin
    if (en[1]) begin
      det_q <= ae - bd;
      nx_q  <= bf - ce;
      ny_q  <= cd - af;
    end
  end

  // stage 2: magnitudes and signs
  logic [DW-1:0] dmag_q;
  logic [MW-1:0] mx_q, my_q;
  logic          negx_q, negy_q, found2_q;
  logic [NNW-1:0] nxm, nym;

  always_comb begin
    nxm = nx_q[NNW-1] ? NNW'(-nx_q) : NNW'(nx_q);
    nym = ny_q[NNW-1] ? NNW'(-ny_q) : NNW'(ny_q);
  end

  always_ff @(posedge clk_i) begin
    if (en[2]) begin
      dmag_q   <= det_q[DW-1] ? DW'(-det_q) : DW'(det_q);
      mx_q     <= MW'(nxm) << FRAC_BITS;
      my_q     <= MW'(nym) << FRAC_BITS;
      negx_q   <= nx_q[NNW-1] ^ det_q[DW-1];
      negy_q   <= ny_q[NNW-1] ^ det_q[DW-1];
      found2_q <= det_q != '0;
    end
  end

  // stage 3: early saturation check, divider setup
  lane_t         lx_q [QUOT_BITS+1];
  lane_t         ly_q [QUOT_BITS+1];
  logic [DW-1:0] dv_q [QUOT_BITS+1];
  logic          fnd_q [QUOT_BITS+1];
  logic [WW-1:0] dtop;

  assign dtop = WW'(dmag_q) << QUOT_BITS;

  always_ff @(posedge clk_i) begin
    if (en[3]) begin
      lx_q[0]  <= '{r: WW'(mx_q), q: '0, neg: negx_q, sat: WW'(mx_q) >= dtop};
      ly_q[0]  <= '{r: WW'(my_q), q: '0, neg: negy_q, sat: WW'(my_q) >= dtop};
      dv_q[0]  <= dmag_q;
      fnd_q[0] <= found2_q;
    end
  end

  // divider stages: one quotient bit each, most significant first
  for (genvar k = 0; k < QUOT_BITS; k++) begin : g_div
    localparam int unsigned SH = QUOT_BITS - 1 - k;
    logic [WW-1:0] dsh;
    lane_t         nx, ny;

    assign dsh = WW'(dv_q[k]) << SH;

    always_comb begin
      nx = lx_q[k];
      ny = ly_q[k];
      if (lx_q[k].r >= dsh) begin
        nx.r     = lx_q[k].r - dsh;
        nx.q[SH] = 1'b1;
      end
      if (ly_q[k].r >= dsh) begin
        ny.r     = ly_q[k].r - dsh;
        ny.q[SH] = 1'b1;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en[4+k]) begin
        lx_q[k+1]  <= nx;
        ly_q[k+1]  <= ny;
        dv_q[k+1]  <= dv_q[k];
        fnd_q[k+1] <= fnd_q[k];
      end
    end
  end

  // last stage: round half away, saturate, apply sign
  function automatic logic [OUT_W:0] finish(lane_t l, logic [DW-1:0] d);
    logic                 rnd;
    logic [QUOT_BITS:0]   qr;
    logic [QUOT_BITS:0]   lim;
    logic [OUT_W-1:0]     mag;
    logic                 over;
    rnd  = {l.r[DW-1:0], 1'b0} >= {1'b0, d};
    qr   = (QUOT_BITS+1)'(l.q) + (QUOT_BITS+1)'(rnd);
    lim  = l.neg ? (QUOT_BITS+1)'(1) << (OUT_W - 1)
                 : ((QUOT_BITS+1)'(1) << (OUT_W - 1)) - (QUOT_BITS+1)'(1);
    over = l.sat || (qr > lim);
    mag  = over ? lim[OUT_W-1:0] : qr[OUT_W-1:0];
    return {over, l.neg ? -mag : mag};
  endfunction

  logic [OUT_W:0]       rx, ry;
  logic signed [31:0]   cx_q, cy_q;
  logic                 fnd_o_q, ovf_o_q;

  assign rx = finish(lx_q[QUOT_BITS], dv_q[QUOT_BITS]);
  assign ry = finish(ly_q[QUOT_BITS], dv_q[QUOT_BITS]);

  always_ff @(posedge clk_i) begin
    if (en[NS-1]) begin
      // zero the coordinates and the overflow flag when the lines are parallel
      cx_q    <= fnd_q[QUOT_BITS] ? rx[OUT_W-1:0] : '0;
      cy_q    <= fnd_q[QUOT_BITS] ? ry[OUT_W-1:0] : '0;
      fnd_o_q <= fnd_q[QUOT_BITS];
      ovf_o_q <= fnd_q[QUOT_BITS] && (rx[OUT_W] || ry[OUT_W]);
    end
  end

  assign out_o.valid      = v_q[NS-1];
  assign out_o.cross_x    = cx_q;
  assign out_o.cross_y    = cy_q;
  assign out_o.found      = fnd_o_q;
  assign out_o.overflowed = ovf_o_q;
endmodule
`default_nettype wire

// ===== design/lli_check.sv =====
// ---------------------------------------------------------------------------
// lli_check
// Port-level checks on the result channel, bound to the top level.
// ---------------------------------------------------------------------------
`default_nettype none
module lli_check (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        out_valid_i,
  input wire logic        out_ready_i,
  input wire logic [31:0] cross_x_i,
  input wire logic [31:0] cross_y_i,
  input wire logic        found_i,
  input wire logic        overflowed_i
);
  a_par_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !found_i |-> cross_x_i == '0 && cross_y_i == '0)
    else $error("parallel result not zero");

  a_par_ovf: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !found_i |-> !overflowed_i)
    else $error("overflow on parallel lines");

  a_ovf_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && overflowed_i |->
      cross_x_i == 32'h7fffffff || cross_x_i == 32'h80000000 ||
      cross_y_i == 32'h7fffffff || cross_y_i == 32'h80000000)
    else $error("overflow without saturated coordinate");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(cross_x_i) && $stable(cross_y_i))
    else $error("stalled word changed");
endmodule

bind line_line_intersection lli_check u_lli_check (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .out_valid_i  (out_o.valid),
  .out_ready_i  (out_o.ready),
  .cross_x_i    (out_o.cross_x),
  .cross_y_i    (out_o.cross_y),
  .found_i      (out_o.found),
  .overflowed_i (out_o.overflowed)
);
`default_nettype wire
